@@ sv/crsr_pkg.sv @@
// Package for the clock-ratio slew ramp: field widths, ramp constants, the sequencer
// state type and the per-field slew function.
// No dependencies; imported by clock_ratio_slew_ramp_top.
package crsr_pkg;

   localparam int unsigned FIELD_W      = 9;
   localparam int unsigned PLL_W        = 14;
   localparam int unsigned NUM_FIELDS   = 4;
   localparam int unsigned RAMP_STEP    = 18;
   localparam int unsigned TICK_LIMIT   = 64;
   localparam int unsigned MAX_OUT      = 58;
   // One result is the echo, so the ramp may take at most MAX_OUT-1 ticks.
   localparam int unsigned TICK_MAX     = (TICK_LIMIT < MAX_OUT - 1) ? TICK_LIMIT : MAX_OUT - 1;
   localparam int unsigned TICK_W       = $clog2(TICK_MAX + 1);
   localparam int unsigned TARGET_SCALE = 10220;
   localparam int unsigned DIVIDEND_W   = 23;
   localparam int unsigned DIV_CNT_W    = $clog2(DIVIDEND_W + 1);

   localparam int unsigned REQ_DATA_W   = 64;
   localparam int unsigned RSP_FIELDS_W = 5 * FIELD_W;
   localparam int unsigned RSP_DATA_W   = 48;
   localparam int unsigned RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [FIELD_W-1:0] RATIO_TOP     = '1;
   localparam logic [FIELD_W:0]   RAMP_STEP_EXT = (FIELD_W + 1)'(RAMP_STEP);

   typedef logic [FIELD_W-1:0] field_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_EMIT
   } state_type;

   // Moves one field toward its goal by at most RAMP_STEP, never overshooting.
   function automatic field_type slew_field(field_type cur, field_type goal);
      logic [FIELD_W:0] up;
      logic [FIELD_W:0] lim;
      logic [FIELD_W:0] down;
      field_type        res;
      up   = {1'b0, cur} + RAMP_STEP_EXT;
      lim  = {1'b0, goal} + RAMP_STEP_EXT;
      down = {1'b0, cur} - RAMP_STEP_EXT;
      res  = cur;
      if (cur < goal) begin
         res = (up > {1'b0, goal}) ? goal : up[FIELD_W-1:0];
      end else if (cur > goal) begin
         res = ({1'b0, cur} < lim) ? goal : down[FIELD_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ sv/clock_ratio_slew_ramp_top.sv @@
// Clock-ratio slew ramp: bus numerator target by serial division, then a stepped ramp
// of the CPU and bus ratio fields. Depends on crsr_pkg.
//
// Usage:
//   req_* carries one ramp request. A transfer takes place when req_tvalid and
//   req_tready are both high; req_tready is high only while the block is idle.
//   rsp_* returns the ramp: first an echo of the current fields, then one set of
//   fields per tick until all four reach their targets or the tick limit is reached;
//   rsp_tlast marks the final transfer of a request. Every result also carries the
//   bus numerator target. Steps: the request is captured, the 14x9 multiply forms
//   the dividend, the restoring divider yields one quotient bit per cycle, and the
//   quotient is clamped before the echo appears; when the bus or PLL frequency is
//   zero no division or clamp is run and the echo follows the multiply. After that
//   one result leaves per cycle while rsp_tready is high, up to 30 results with
//   the ramp step of 18. The block takes no new request until its last result.
//   A low rsp_tready simply holds the current result and the sequencer.
//   Reset returns the sequencer to idle and drops rsp_tvalid; no request is kept.
module clock_ratio_slew_ramp_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // bus_mhz[8:0], pll_freq_x10[22:9], cur_cpu_num[31:23], cur_cpu_den[40:32],
   // cur_bus_num[49:41], cur_bus_den[58:50], zeros above
   input  logic [crsr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cpu_ratio_num[8:0], cpu_ratio_den[17:9], bus_ratio_num[26:18],
   // bus_ratio_den[35:27], bus_num_target[44:36], zeros above
   output logic [crsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import crsr_pkg::*;

   state_type             state_ff, state_in;
   logic [FIELD_W-1:0]    bus_ff, bus_in;
   logic [PLL_W-1:0]      pll_ff, pll_in;
   field_type             fld_ff [NUM_FIELDS];
   field_type             fld_in [NUM_FIELDS];
   field_type             goal   [NUM_FIELDS];
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [PLL_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   field_type             target_ff, target_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  zero_case;
   logic                  div_done;
   logic                  match;
   logic                  last;
   logic [PLL_W:0]        trial;
   logic [PLL_W:0]        trial_diff;
   logic                  trial_ge;
   logic [DIVIDEND_W-1:0] dividend;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   assign zero_case = (bus_ff == '0) || (pll_ff == '0);
   assign div_done  = (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1));

   // Rounded dividend: scale * bus + pll / 2.
   assign dividend = DIVIDEND_W'(TARGET_SCALE) * DIVIDEND_W'(bus_ff)
                     + DIVIDEND_W'(pll_ff >> 1);

   // Restoring-division step: shift in the next dividend bit and try a subtract.
   assign trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_diff = trial - {1'b0, pll_ff};
   assign trial_ge   = (trial >= {1'b0, pll_ff});

   always_comb begin
      goal[0] = RATIO_TOP;
      goal[1] = RATIO_TOP;
      goal[2] = target_ff;
      goal[3] = RATIO_TOP;
   end

   always_comb begin
      match = 1'b1;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (fld_ff[i] != goal[i]) begin
            match = 1'b0;
         end
      end
   end

   assign last = match || (tick_ff == TICK_W'(TICK_MAX));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = zero_case ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_xfer && last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tlast  = last;
      rsp_tdata  = {{RSP_PAD_W{1'b0}}, target_ff, fld_ff[3], fld_ff[2], fld_ff[1], fld_ff[0]};
   end

   // Datapath next values.
   always_comb begin
      bus_in    = bus_ff;
      pll_in    = pll_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      target_in = target_ff;
      tick_in   = tick_ff;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         fld_in[i] = fld_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               bus_in    = req_tdata[FIELD_W-1:0];
               pll_in    = req_tdata[FIELD_W +: PLL_W];
               for (int i = 0; i < NUM_FIELDS; i++) begin
                  fld_in[i] = req_tdata[FIELD_W + PLL_W + i * FIELD_W +: FIELD_W];
               end
            end
         end
         ST_MUL: begin
            quo_in    = dividend;
            rem_in    = '0;
            cnt_in    = '0;
            target_in = RATIO_TOP;
            tick_in   = '0;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff[PLL_W-1:0] : trial[PLL_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_CLAMP: begin
            if (quo_ff == '0) begin
               target_in = FIELD_W'(1);
            end else if (quo_ff > DIVIDEND_W'(RATIO_TOP)) begin
               target_in = RATIO_TOP;
            end else begin
               target_in = quo_ff[FIELD_W-1:0];
            end
            tick_in = '0;
         end
         ST_EMIT: begin
            if (rsp_xfer && !last) begin
               for (int i = 0; i < NUM_FIELDS; i++) begin
                  fld_in[i] = slew_field(fld_ff[i], goal[i]);
               end
               tick_in = tick_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bus_ff    <= bus_in;
      pll_ff    <= pll_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      target_ff <= target_in;
      tick_ff   <= tick_in;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         fld_ff[i] <= fld_in[i];
      end
   end

endmodule
